>>> rtl/core/assert_macros.svh
// Assertion helpers: clocked on aclk, idle while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/jseu_pkg.sv
package jseu_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam logic [3:0] ST_ACCEPT = 4'd0;
    localparam logic [3:0] ST_REJECT = 4'd1;
    localparam logic [3:0] ST_LAST   = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PLAIN,
        CMD_ESC,
        CMD_CTRL,
        CMD_FLUSH,
        CMD_BAD,
        CMD_TERM
    } cmd_kind_t;

    // One request from the front end to the back end.
    typedef struct packed {
        cmd_kind_t        kind;
        logic             open_quote;
        logic             bad;
        logic [7:0]       data;
        logic [1:0]       held_count;
        logic [2:0][7:0]  held;
    } cmd_t;

    localparam logic [3:0] NEXT_STATE [9][12] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic logic [3:0] byte_class(input logic [7:0] b);
        logic [3:0] cls;
        if (b < 8'h80)       cls = 4'd0;
        else if (b < 8'h90)  cls = 4'd1;
        else if (b < 8'hA0)  cls = 4'd9;
        else if (b < 8'hC0)  cls = 4'd7;
        else if (b < 8'hC2)  cls = 4'd8;
        else if (b < 8'hE0)  cls = 4'd2;
        else if (b == 8'hE0) cls = 4'd10;
        else if (b == 8'hED) cls = 4'd4;
        else if (b < 8'hF0)  cls = 4'd3;
        else if (b == 8'hF0) cls = 4'd11;
        else if (b < 8'hF4)  cls = 4'd6;
        else if (b == 8'hF4) cls = 4'd5;
        else                 cls = 4'd8;
        return cls;
    endfunction

    function automatic logic [3:0] dfa_next(input logic [3:0] st, input logic [3:0] cls);
        logic [3:0] s;
        s = (st > ST_LAST) ? ST_REJECT : st;
        return NEXT_STATE[s][cls];
    endfunction

endpackage

>>> rtl/core/jseu_front.sv
`include "assert_macros.svh"

module jseu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic [7:0]    s_in_byte,
    output logic          push,
    output jseu_pkg::cmd_t cmd
);
    import jseu_pkg::*;

    logic             string_open_reg, string_open_next;
    logic [3:0]       utf8_state_reg, utf8_state_next;
    logic [1:0]       held_count_reg, held_count_next;
    logic [2:0][7:0]  held_reg, held_next;
    logic [3:0]       cls;
    logic [3:0]       ns;
    logic             accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        cls = byte_class(s_in_byte);
        ns  = dfa_next(utf8_state_reg, cls);

        string_open_next = string_open_reg;
        utf8_state_next  = utf8_state_reg;
        held_count_next  = held_count_reg;
        held_next        = held_reg;

        cmd            = '0;
        cmd.kind       = CMD_NONE;
        cmd.open_quote = !string_open_reg;
        cmd.data       = s_in_byte;
        cmd.held_count = held_count_reg;
        cmd.held       = held_reg;

        if (s_in_byte == 8'h00) begin
            cmd.kind        = CMD_TERM;
            cmd.bad         = (utf8_state_reg != ST_ACCEPT);
            utf8_state_next = ST_ACCEPT;
            held_count_next = 2'd0;
        end else if (utf8_state_reg != ST_ACCEPT || s_in_byte[7]) begin
            if (ns == ST_ACCEPT) begin
                cmd.kind        = CMD_FLUSH;
                held_count_next = 2'd0;
                utf8_state_next = ST_ACCEPT;
            end else if (ns == ST_REJECT) begin
                cmd.kind        = CMD_BAD;
                held_count_next = 2'd0;
                utf8_state_next = ST_ACCEPT;
            end else begin
                // hold the byte until the sequence completes
                if (held_count_reg != 2'd3) begin
                    held_next[held_count_reg] = s_in_byte;
                    held_count_next = held_count_reg + 2'd1;
                end
                utf8_state_next = ns;
            end
        end else if (s_in_byte == CH_QUOTE || s_in_byte == CH_BSLASH) begin
            cmd.kind = CMD_ESC;
        end else if (s_in_byte < CTRL_LIMIT) begin
            cmd.kind = CMD_CTRL;
        end else begin
            cmd.kind = CMD_PLAIN;
        end

        string_open_next = (s_in_byte != 8'h00);
    end

    assign push = accept && (cmd.kind != CMD_NONE || cmd.open_quote);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            string_open_reg <= 1'b0;
            utf8_state_reg  <= ST_ACCEPT;
            held_count_reg  <= 2'd0;
        end else if (accept) begin
            string_open_reg <= string_open_next;
            utf8_state_reg  <= utf8_state_next;
            held_count_reg  <= held_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

    `ASSERT_IMP(a_held_in_seq, held_count_reg != 2'd0, utf8_state_reg != ST_ACCEPT)
    `ASSERT_IMP(a_state_range, 1'b1, utf8_state_reg <= ST_LAST)

endmodule

>>> rtl/core/jseu_queue.sv
`include "assert_macros.svh"

module jseu_queue #(
    parameter int DEPTH = jseu_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  jseu_pkg::cmd_t push_cmd,
    output logic           not_full,
    output logic           q_valid,
    output jseu_pkg::cmd_t q_cmd,
    input  logic           pop
);
    import jseu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t           mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;

    assign not_full = (count_reg != CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMP(a_no_overflow, push, count_reg != CNT_FULL)
    `ASSERT_NXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - CW'(1))

endmodule

>>> rtl/core/jseu_back.sv
`include "assert_macros.svh"

module jseu_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  jseu_pkg::cmd_t q_cmd,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_has_byte,
    output logic           m_bad_sequence,
    output logic           m_string_done,
    output logic           m_last_of_run
);
    import jseu_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        has_reg, bad_reg, done_reg, last_reg;

    logic        load;
    logic        short_ctrl;
    logic [2:0]  body_len;
    logic [2:0]  total;
    logic [2:0]  k;
    logic        is_last;
    logic [7:0]  r_byte;
    logic        r_has, r_bad, r_done;
    logic [7:0]  ctrl_letter;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + {4'd0, n} : CH_LOWER_A + {4'd0, n} - 8'd10;
    endfunction

    assign load = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        short_ctrl  = 1'b1;
        ctrl_letter = CH_LOWER_U;
        case (q_cmd.data)
            8'd8:    ctrl_letter = 8'h62;
            8'd9:    ctrl_letter = 8'h74;
            8'd10:   ctrl_letter = 8'h6E;
            8'd12:   ctrl_letter = 8'h66;
            8'd13:   ctrl_letter = 8'h72;
            default: short_ctrl  = 1'b0;
        endcase

        case (q_cmd.kind)
            CMD_PLAIN: body_len = 3'd1;
            CMD_ESC:   body_len = 3'd2;
            CMD_CTRL:  body_len = short_ctrl ? 3'd2 : 3'd6;
            CMD_FLUSH: body_len = {1'b0, q_cmd.held_count} + 3'd1;
            CMD_BAD:   body_len = 3'd1;
            CMD_TERM:  body_len = q_cmd.bad ? 3'd2 : 3'd1;
            default:   body_len = 3'd0;
        endcase

        total   = body_len + {2'd0, q_cmd.open_quote};
        is_last = (idx_reg == total - 3'd1);
        k       = idx_reg - {2'd0, q_cmd.open_quote};

        r_byte = 8'h00;
        r_has  = 1'b1;
        r_bad  = 1'b0;
        r_done = 1'b0;
        if (q_cmd.open_quote && idx_reg == 3'd0) begin
            r_byte = CH_QUOTE;
        end else begin
            case (q_cmd.kind)
                CMD_PLAIN: r_byte = q_cmd.data;
                CMD_ESC:   r_byte = (k == 3'd0) ? CH_BSLASH : q_cmd.data;
                CMD_CTRL: begin
                    case (k)
                        3'd0:    r_byte = CH_BSLASH;
                        3'd1:    r_byte = ctrl_letter;
                        3'd2:    r_byte = CH_ZERO;
                        3'd3:    r_byte = CH_ZERO;
                        3'd4:    r_byte = hex_digit(q_cmd.data[7:4]);
                        default: r_byte = hex_digit(q_cmd.data[3:0]);
                    endcase
                end
                CMD_FLUSH: begin
                    // replay the held lead bytes, then the closing byte
                    if (k < {1'b0, q_cmd.held_count}) begin
                        r_byte = q_cmd.held[k[1:0]];
                    end else begin
                        r_byte = q_cmd.data;
                    end
                end
                CMD_BAD: begin
                    r_has = 1'b0;
                    r_bad = 1'b1;
                end
                CMD_TERM: begin
                    if (q_cmd.bad && k == 3'd0) begin
                        r_has = 1'b0;
                        r_bad = 1'b1;
                    end else begin
                        r_byte = CH_QUOTE;
                        r_done = 1'b1;
                    end
                end
                default: r_has = 1'b0;
            endcase
        end

        idx_next = idx_reg;
        if (load) begin
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    assign pop = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= r_byte;
            has_reg      <= r_has;
            bad_reg      <= r_bad;
            done_reg     <= r_done;
            last_reg     <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_has_byte     = has_reg;
    assign m_bad_sequence = bad_reg;
    assign m_string_done  = done_reg;
    assign m_last_of_run  = last_reg;

    `ASSERT_IMP(a_idx_in_range, q_valid, idx_reg < total)

endmodule

>>> rtl/core/json_string_escaper_utf8_check.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_in_byte
// m_        out        m_valid/m_ready    m_out_byte m_has_byte m_bad_sequence
//                                         m_string_done m_last_of_run
//
// An input byte is taken every cycle while the request queue has room; the
// back-end sequencer issues one result per cycle while m_ready is high, so a
// byte yields 1 to 7 results (7 for an opening quote plus a \u00XX escape), a
// held UTF-8 byte with no quote due yields none. The first result passes
// through a queue entry and the output register before it is offered. aresetn
// (synchronous) clears string, automaton, queue and output valid. m_ready low
// holds the output; once DEPTH requests wait, s_ready drops.
module json_string_escaper_utf8_check #(
    parameter int DEPTH = jseu_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_bad_sequence,
    output logic       m_string_done,
    output logic       m_last_of_run
);
    import jseu_pkg::*;

    logic  push;
    cmd_t  push_cmd;
    logic  q_valid;
    cmd_t  q_cmd;
    logic  pop;

    jseu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .push      (push),
        .cmd       (push_cmd)
    );

    jseu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .not_full (s_ready),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    jseu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_bad_sequence (m_bad_sequence),
        .m_string_done  (m_string_done),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

>>> sim/tb_json_string_escaper_utf8_check.sv
module tb_json_string_escaper_utf8_check;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        U_ACCEPT,
        U_REJECT,
        U_TAIL1,
        U_TAIL2,
        U_E0,
        U_ED,
        U_F0,
        U_TAIL3,
        U_F4
    } utf8_state_e;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       bad_sequence;
        logic       string_done;
        logic       last_of_run;
    } json_result_t;

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5c;

    class escape_scoreboard;
        bit           in_string;
        utf8_state_e  utf8_st;
        logic [7:0]   held [3];
        int           held_n;
        json_result_t step_q[$];
        json_result_t pending_q[$];
        int           errors;

        function new();
            in_string = 1'b0;
            utf8_st   = U_ACCEPT;
            held_n    = 0;
            errors    = 0;
        endfunction

        function void add(logic [7:0] d, logic has, logic bad, logic done);
            step_q.push_back({d, has, bad, done, 1'b0});
        endfunction

        function logic [7:0] hex_char(logic [3:0] v);
            return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h57 + {4'h0, v};
        endfunction

        function utf8_state_e utf8_next(utf8_state_e st, logic [7:0] b);
            utf8_state_e n;
            logic        tail;
            n    = U_REJECT;
            tail = (b >= 8'h80 && b <= 8'hbf);
            case (st)
                U_ACCEPT: begin
                    if (b < 8'h80)                    n = U_ACCEPT;
                    else if (b >= 8'hc2 && b <= 8'hdf) n = U_TAIL1;
                    else if (b == 8'he0)               n = U_E0;
                    else if (b == 8'hed)               n = U_ED;
                    else if (b >= 8'he1 && b <= 8'hef) n = U_TAIL2;
                    else if (b == 8'hf0)               n = U_F0;
                    else if (b >= 8'hf1 && b <= 8'hf3) n = U_TAIL3;
                    else if (b == 8'hf4)               n = U_F4;
                end
                U_TAIL1: if (tail) n = U_ACCEPT;
                U_TAIL2: if (tail) n = U_TAIL1;
                U_TAIL3: if (tail) n = U_TAIL2;
                U_E0:    if (b >= 8'ha0 && b <= 8'hbf) n = U_TAIL1;
                U_ED:    if (b >= 8'h80 && b <= 8'h9f) n = U_TAIL1;
                U_F0:    if (b >= 8'h90 && b <= 8'hbf) n = U_TAIL2;
                U_F4:    if (b >= 8'h80 && b <= 8'h8f) n = U_TAIL2;
                default: n = U_REJECT;
            endcase
            return n;
        endfunction

        function void note_request(logic [7:0] b);
            utf8_state_e  nxt;
            json_result_t r;
            step_q.delete();
            if (!in_string) begin
                add(CHR_QUOTE, 1'b1, 1'b0, 1'b0);
                in_string = 1'b1;
            end
            if (b == CHR_NUL) begin
                // a terminator inside a sequence drops what is held
                if (utf8_st != U_ACCEPT) add(8'h00, 1'b0, 1'b1, 1'b0);
                utf8_st   = U_ACCEPT;
                held_n    = 0;
                add(CHR_QUOTE, 1'b1, 1'b0, 1'b1);
                in_string = 1'b0;
            end else if (utf8_st != U_ACCEPT || b >= 8'h80) begin
                nxt = utf8_next(utf8_st, b);
                if (nxt == U_ACCEPT) begin
                    for (int i = 0; i < held_n; i++) add(held[i], 1'b1, 1'b0, 1'b0);
                    add(b, 1'b1, 1'b0, 1'b0);
                    held_n  = 0;
                    utf8_st = U_ACCEPT;
                end else if (nxt == U_REJECT) begin
                    // drop held bytes and the offending byte, even if ASCII
                    add(8'h00, 1'b0, 1'b1, 1'b0);
                    held_n  = 0;
                    utf8_st = U_ACCEPT;
                end else begin
                    if (held_n < 3) begin
                        held[held_n] = b;
                        held_n++;
                    end
                    utf8_st = nxt;
                end
            end else if (b == CHR_QUOTE || b == CHR_BSLASH) begin
                add(CHR_BSLASH, 1'b1, 1'b0, 1'b0);
                add(b, 1'b1, 1'b0, 1'b0);
            end else if (b < 8'h20) begin
                add(CHR_BSLASH, 1'b1, 1'b0, 1'b0);
                case (b)
                    8'h08: add("b", 1'b1, 1'b0, 1'b0);
                    8'h09: add("t", 1'b1, 1'b0, 1'b0);
                    8'h0a: add("n", 1'b1, 1'b0, 1'b0);
                    8'h0c: add("f", 1'b1, 1'b0, 1'b0);
                    8'h0d: add("r", 1'b1, 1'b0, 1'b0);
                    default: begin
                        add("u", 1'b1, 1'b0, 1'b0);
                        add("0", 1'b1, 1'b0, 1'b0);
                        add("0", 1'b1, 1'b0, 1'b0);
                        add(hex_char(b[7:4]), 1'b1, 1'b0, 1'b0);
                        add(hex_char(b[3:0]), 1'b1, 1'b0, 1'b0);
                    end
                endcase
            end else begin
                add(b, 1'b1, 1'b0, 1'b0);
            end
            foreach (step_q[i]) begin
                r = step_q[i];
                r.last_of_run = (i == step_q.size() - 1);
                pending_q.push_back(r);
            end
        endfunction

        function void check_result(json_result_t got);
            json_result_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: byte %02h has %b bad %b done %b last %b",
                         $time, got.data, got.has_byte, got.bad_sequence, got.string_done,
                         got.last_of_run);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: expected byte %02h has %b bad %b done %b last %b",
                         $time, want.data, want.has_byte, want.bad_sequence,
                         want.string_done, want.last_of_run);
                $display("%0t:   actual byte %02h has %b bad %b done %b last %b",
                         $time, got.data, got.has_byte, got.bad_sequence, got.string_done,
                         got.last_of_run);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_bad_sequence;
    logic       m_string_done;
    logic       m_last_of_run;

    escape_scoreboard sb;
    logic [7:0]       text_q[$];
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               hold_left = 0;

    json_string_escaper_utf8_check uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_bad_sequence (m_bad_sequence),
        .m_string_done  (m_string_done),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: check accepted results, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_out_byte, m_has_byte, m_bad_sequence, m_string_done,
                             m_last_of_run});
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [3:0][7:0] random_utf8(input int n);
        logic [3:0][7:0] s;
        int              pick;
        s    = '0;
        pick = $urandom_range(2);
        for (int i = 1; i < 4; i++) s[i] = 8'($urandom_range(8'h80, 8'hbf));
        case (n)
            2: s[0] = 8'($urandom_range(8'hc2, 8'hdf));
            3: begin
                if (pick == 0) begin
                    s[0] = 8'he0;
                    s[1] = 8'($urandom_range(8'ha0, 8'hbf));
                end else if (pick == 1) begin
                    s[0] = 8'hed;
                    s[1] = 8'($urandom_range(8'h80, 8'h9f));
                end else begin
                    s[0] = 8'($urandom_range(8'he1, 8'hef));
                    if (s[0] == 8'hed) s[0] = 8'hee;
                end
            end
            default: begin
                if (pick == 0) begin
                    s[0] = 8'hf0;
                    s[1] = 8'($urandom_range(8'h90, 8'hbf));
                end else if (pick == 1) begin
                    s[0] = 8'hf4;
                    s[1] = 8'($urandom_range(8'h80, 8'h8f));
                end else begin
                    s[0] = 8'($urandom_range(8'hf1, 8'hf3));
                end
            end
        endcase
        return s;
    endfunction

    // build one string: mostly well-formed text, some noise, broken and cut sequences
    task automatic queue_random_string();
        int              pieces;
        int              r;
        int              n;
        int              k;
        bit              cut;
        logic [3:0][7:0] seq;
        pieces = $urandom_range(0, 8);
        cut    = 1'b0;
        for (int p = 0; p < pieces && !cut; p++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
            end else if (r < 38) begin
                text_q.push_back($urandom_range(1) ? CHR_QUOTE : CHR_BSLASH);
            end else if (r < 48) begin
                text_q.push_back(8'($urandom_range(1, 31)));
            end else if (r < 80) begin
                n   = (r < 58) ? 2 : (r < 68) ? 3 : 4;
                seq = random_utf8(n);
                for (int i = 0; i < n; i++) text_q.push_back(seq[i]);
            end else if (r < 90) begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end else begin
                n   = $urandom_range(2, 4);
                k   = $urandom_range(1, n - 1);
                seq = random_utf8(n);
                for (int i = 0; i < k; i++) text_q.push_back(seq[i]);
                if (r < 95)
                    text_q.push_back($urandom_range(1) ? 8'($urandom_range(1, 8'h7f))
                                                       : 8'($urandom_range(8'hc0, 8'hff)));
                else
                    cut = 1'b1;
            end
        end
        text_q.push_back(CHR_NUL);
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(b);
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    // drop the request and wait until every pending result is out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int sent;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty string, escapes, controls, good/bad/cut UTF-8
        text_q = '{8'h00,
                   8'h22, 8'h5c, 8'h08, 8'h09, 8'h0a, 8'h0c, 8'h0d, 8'h01, 8'h1f,
                   8'h7f, 8'h20, 8'h00,
                   8'hc3, 8'ha9, 8'hf0, 8'h90, 8'h80, 8'h80, 8'hc3, 8'h41, 8'hff,
                   8'he2, 8'h82, 8'h00};
        send_text();

        for (int ph = 0; ph < 4; ph++) begin
            // hold the sender until every pending result is out
            wait_drained();
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    hold_left = 80;
                end
                1: begin
                    idle_pct  = 67;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 67;
                end
                default: begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            sent = 0;
            while (sent < 32) begin
                queue_random_string();
                sent += text_q.size();
                send_text();
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
